// ===== rtl/half_pel_row_interpolator_defines.svh =====
// Assertion macros shared by the half-pel row interpolator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef HALF_PEL_ROW_INTERPOLATOR_DEFINES_SVH
`define HALF_PEL_ROW_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define HPRI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpri assertion failed");
// Next-cycle implication, disabled while reset is held.
`define HPRI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpri assertion failed");
`else
`define HPRI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HPRI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/hpri_pkg.sv =====
// Types and constants of the half-pel row interpolator.
// No dependencies; imported by every module of the block.
package hpri_pkg;

  localparam int ROW_PIXELS    = 8;
  localparam int ACTIVE_PIXELS = (ROW_PIXELS > 8) ? 8 : ROW_PIXELS;
  localparam int PIX_W         = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int IN_DATA_W     = 136;
  localparam int OUT_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 2;

  typedef enum logic [1:0] {
    MODE_COPY  = 2'd0,
    MODE_HORIZ = 2'd1,
    MODE_VERT  = 2'd2,
    MODE_DIAG  = 2'd3
  } interp_mode_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MODE       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_NO_ROUND   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ACCUMULATE = 2'd2;

  typedef logic [8:0][PIX_W-1:0] ref_row_t;
  typedef logic [7:0][PIX_W-1:0] pix_row_t;

  // One unit of work handed from the front to the back
  typedef struct packed {
    interp_mode_t mode;
    logic         no_round;
    logic         accumulate;
    ref_row_t     cur;
    ref_row_t     prev;
    pix_row_t     dest;
    logic         last;
  } hpri_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hpri_q_stat_t;

endpackage

// ===== rtl/hpri_front.sv =====
// Front end: configuration registers, previous-row store, item classification.
// Depends on hpri_pkg.
module hpri_front import hpri_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   in_tlast,
  input  logic                   in_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  hpri_q_stat_t           q_stat,
  output logic                   push,
  output hpri_item_t             push_item
);

  interp_mode_t mode_r;
  logic         no_round_r;
  logic         accumulate_r;
  ref_row_t     prev_row_r;
  ref_row_t     cur_row;
  logic         accept;
  logic         drop;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign cur_row   = in_tdata[71:0];
  // Priming rows in vertical or diagonal mode only load the row store
  assign drop      = in_tuser && (mode_r == MODE_VERT || mode_r == MODE_DIAG);
  assign push      = accept && !drop;

  always_comb begin
    push_item.mode       = mode_r;
    push_item.no_round   = no_round_r;
    push_item.accumulate = accumulate_r;
    push_item.cur        = cur_row;
    push_item.prev       = prev_row_r;
    push_item.dest       = in_tdata[135:72];
    push_item.last       = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_COPY;
      no_round_r   <= 1'b0;
      accumulate_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      priority if (cfg_index == CFG_IDX_MODE) begin
        mode_r <= interp_mode_t'(cfg_data[1:0]);
      end else if (cfg_index == CFG_IDX_NO_ROUND) begin
        no_round_r <= cfg_data[0];
      end else if (cfg_index == CFG_IDX_ACCUMULATE) begin
        accumulate_r <= cfg_data[0];
      end
    end
  end

  // Every accepted row becomes the previous row, dropped or not
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_row_r <= cur_row;
    end
  end

endmodule

// ===== rtl/hpri_queue.sv =====
// Short queue between front and back of the half-pel row interpolator.
// Depends on hpri_pkg and the assertion macro header.
`include "half_pel_row_interpolator_defines.svh"
module hpri_queue import hpri_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  hpri_item_t   push_item,
  input  logic         pop,
  output hpri_item_t   pop_item,
  output hpri_q_stat_t q_stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  hpri_item_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_FULL);
  assign q_stat.empty = (count_r == '0);
  assign pop_item     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_ONE;
      2'b01:   count_nxt = count_r - CNT_ONE;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  `HPRI_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !q_stat.full)
  `HPRI_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !q_stat.empty)
  `HPRI_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + CNT_ONE)
  `HPRI_ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push, count_r == $past(count_r) - CNT_ONE)

endmodule

// ===== rtl/hpri_back.sv =====
// Back end: per-pixel bilinear averaging and the output register.
// Depends on hpri_pkg.
module hpri_back import hpri_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hpri_q_stat_t          q_stat,
  input  hpri_item_t            pop_item,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_pixels_r;
  logic                  out_last_r;
  pix_row_t              result;

  function automatic logic [PIX_W-1:0] pel_calc(
    input interp_mode_t     mode,
    input logic             no_round,
    input logic             accumulate,
    input logic [PIX_W-1:0] a,
    input logic [PIX_W-1:0] b,
    input logic [PIX_W-1:0] c,
    input logic [PIX_W-1:0] d,
    input logic [PIX_W-1:0] dst
  );
    logic [PIX_W+1:0] sum;
    logic [PIX_W-1:0] v;
    logic [PIX_W:0]   acc;
    sum = '0;
    v   = a;
    unique case (mode)
      MODE_COPY: begin
        v = a;
      end
      MODE_HORIZ: begin
        sum = {2'b00, a} + {2'b00, b} + {9'd0, !no_round};
        v   = sum[PIX_W:1];
      end
      MODE_VERT: begin
        sum = {2'b00, c} + {2'b00, a} + {9'd0, !no_round};
        v   = sum[PIX_W:1];
      end
      MODE_DIAG: begin
        sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d}
            + (no_round ? 10'd1 : 10'd2);
        v   = sum[PIX_W+1:2];
      end
      default: v = a;
    endcase
    acc = {1'b0, dst} + {1'b0, v} + 9'd1;
    return accumulate ? acc[PIX_W:1] : v;
  endfunction

  always_comb begin
    result = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < ACTIVE_PIXELS) begin
        result[k] = pel_calc(pop_item.mode, pop_item.no_round, pop_item.accumulate,
                             pop_item.cur[k], pop_item.cur[k+1],
                             pop_item.prev[k], pop_item.prev[k+1],
                             pop_item.dest[k]);
      end
    end
  end

  // Take the head item whenever the output register is free or draining
  assign pop = !q_stat.empty && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_pixels_r <= result;
      out_last_r   <= pop_item.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixels_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/half_pel_row_interpolator.sv =====
// Top level of the half-pel row interpolator: front, queue and back joined.
// Depends on hpri_pkg, hpri_front, hpri_queue and hpri_back.
//
// Usage
//   Input stream (in_*): one transaction per reference row. tdata carries the
//   eight reference pixels, the pixel to their right and the destination row;
//   tuser flags the first row of a block, tlast the final row.
//   Output stream (out_*): one transaction per interpolated row, tlast copied
//   from the row that caused it. In vertical and diagonal modes a flagged
//   first row only loads the row store and gives no output transaction.
//   Configuration (cfg_*): register writes, always ready; write only while
//   the block is idle. Index 0 mode, 1 no-round, 2 accumulate.
//   Throughput: one row per cycle while out_tready stays high, set by the
//   combinational averaging datapath in the back end. An accepted row passes
//   the queue stage, then the output register, before it appears on out_*.
//   Reset (rst_n low, synchronous): clears configuration, queue and output
//   valid. The row store is not cleared and holds nothing until a row loads it;
//   no clearing pass.
//   Receiver stall: the output register holds; the two-entry queue absorbs
//   rows in flight, after which in_tready falls until the receiver drains.
module half_pel_row_interpolator import hpri_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata, low bit up: ref_pixels[63:0], ref_right_pixel[71:64], dest_pixels[135:72]
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   in_tlast,
  // tuser: prime_row
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: out_pixels[63:0]
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  hpri_q_stat_t q_stat;
  logic         push;
  logic         pop;
  hpri_item_t   push_item;
  hpri_item_t   pop_item;

  // Classify rows and hold the previous row
  hpri_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple the two halves so each may stall on its own
  hpri_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // Average and register the result row
  hpri_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
